// ===== sv/assembly_nx_quartile_scan_top_macros.svh =====
// assertion macros for the assembly nx quartile scan block
// used by the rtl files in this folder, no other dependencies
`ifndef ASSEMBLY_NX_QUARTILE_SCAN_TOP_MACROS_SVH
`define ASSEMBLY_NX_QUARTILE_SCAN_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// next-cycle implication
`define AQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define AQS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AQS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/aqs_pkg.sv =====
// shared types and constants for the assembly nx quartile scan block
// no dependencies
`default_nettype none

package aqs_pkg;

    localparam int LengthBits = 32;
    localparam int InW        = 32;
    localparam int CntW       = 32;
    localparam int SumW       = 48;
    localparam int PctW       = 7;
    localparam int TpW        = SumW + PctW;
    localparam int StatValW   = 32;
    localparam int StatIdW    = 4;
    localparam int NumStats   = 16;
    localparam int NumQuart   = 3;
    localparam int NumLimits  = 5;
    localparam int NumNx      = 4;
    localparam int StatOlBase = 3;
    localparam int StatNxBase = 8;
    localparam int CfgAddrW   = 3;
    localparam int CfgDataW   = 48;
    localparam int QueueDepth = 2;
    localparam int TuserW     = StatIdW + 1;

    localparam logic [InW-1:0] LenMask = InW'((64'd1 << LengthBits) - 64'd1);

    localparam logic [NumLimits-1:0][InW-1:0] Limits = {
        32'd1000000, 32'd100000, 32'd10000, 32'd1000, 32'd500
    };

    // config register indexes
    typedef enum logic [CfgAddrW-1:0] {
        RegTotalLength, RegSeqCount, RegGenomeLength, RegPctA, RegPctB
    } t_cfg_reg;

    typedef struct packed {
        logic [NumStats-1:0]                avail;
        logic [NumStats-1:0][StatValW-1:0] value;
    } t_snap;

endpackage

`default_nettype wire

// ===== sv/assembly_nx_quartile_scan_top.sv =====
// channel    dir  tdata                         tuser                 tlast
// s_axis     in   [31:0] length, [63:32] count  -                     last_entry
// m_axis     out  [31:0] stat_value             [3:0] id, [4] avail   last_result
// cfg        in   write enable, index [2:0], data [47:0]
//
// one histogram entry per cycle while s_axis_tready is high; an entry reaches the
// statistics state through the multiply, saturating-sum and compare registers
// a last entry yields 16 results, one per ready cycle, from a two-set result queue
// input stalls only when a last entry meets a full result queue
// synchronous reset restores config defaults and clears valid flags and statistics
// top level of the assembly nx quartile scan; depends on aqs_pkg, aqs_front,
// aqs_queue and aqs_back
`default_nettype none

module assembly_nx_quartile_scan_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*aqs_pkg::InW-1:0]           s_axis_tdata,   // length, count
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [aqs_pkg::StatValW-1:0]        m_axis_tdata,   // stat_value
    output logic [aqs_pkg::TuserW-1:0]          m_axis_tuser,   // stat_id, available
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [aqs_pkg::CfgAddrW-1:0]        i_cfg_addr,
    input  logic [aqs_pkg::CfgDataW-1:0]        i_cfg_wdata
);
    import aqs_pkg::*;

    t_snap               push_data, head_data;
    logic                push, pop, q_full, q_valid;
    logic [StatIdW-1:0]  stat_id;
    logic                available;

    aqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_length    (s_axis_tdata[InW-1:0]),
        .i_count     (s_axis_tdata[2*InW-1:InW]),
        .i_last      (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_snap      (push_data)
    );

    aqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_data),
        .i_pop   (pop)
    );

    aqs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (head_data),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_stat_id    (stat_id),
        .o_stat_value (m_axis_tdata),
        .o_available  (available),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {available, stat_id};

endmodule

`default_nettype wire

// ===== sv/aqs_front.sv =====
// front part: config registers, entry pipeline and running statistics
// depends on aqs_pkg and the assertion macro header
`default_nettype none
`include "assembly_nx_quartile_scan_top_macros.svh"

module aqs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [aqs_pkg::InW-1:0]        i_length,
    input  logic [aqs_pkg::CntW-1:0]       i_count,
    input  logic                           i_last,
    input  logic                           i_cfg_we,
    input  logic [aqs_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [aqs_pkg::CfgDataW-1:0]   i_cfg_wdata,
    input  logic                           i_q_full,
    output logic                           o_push,
    output aqs_pkg::t_snap                 o_snap
);
    import aqs_pkg::*;

    localparam logic [SumW-1:0]     SumMax          = '1;

    // config registers and derived values
    logic [SumW-1:0]  r_total, r_genome;
    logic [CntW-1:0]  r_seq;
    logic [PctW-1:0]  r_pct_a, r_pct_b;
    logic [NumNx-1:0][TpW-1:0] r_tp;
    logic             r_gen_on;
    logic [CntW-1:0]  r_half, r_fourth, r_three;

    // pipeline
    logic             en;
    logic             r1_valid, r2_valid, r3_valid;
    logic             r1_last, r2_last, r3_last;
    logic [InW-1:0]   r1_len, r2_len, r3_len;
    logic [CntW-1:0]  r1_cnt;
    logic [2*InW-1:0] r1_prod;
    logic [SumW-1:0]  r_acc_len, r2_lsum, n_lsum;
    logic [CntW-1:0]  r_acc_cnt, r2_csum, r3_csum, n_csum;
    logic [2*InW:0]   lsum_wide;
    logic [CntW:0]    csum_wide;
    logic [TpW-1:0]   r3_s100;
    logic [NumQuart-1:0]  r3_qhit;
    logic [NumLimits-1:0] r3_ohit;

    // statistics state
    logic [NumQuart-1:0][InW-1:0]   r_q, n_q;
    logic [NumLimits-1:0][CntW-1:0] r_ol, n_ol;
    logic [NumNx-1:0][InW-1:0]      r_nl, n_nl;
    logic [NumNx-1:0][CntW-1:0]     r_lx, n_lx;
    logic [NumNx-1:0]               r_reached, n_reached;
    logic                           avail_nx;

    assign en      = !(r3_valid && r3_last && i_q_full);
    assign o_ready = en;
    assign o_push  = r3_valid && r3_last && en;

    // saturating running sums
    always_comb begin
        lsum_wide = {17'b0, r_acc_len} + {1'b0, r1_prod};
        n_lsum    = (|lsum_wide[2*InW:SumW]) ? SumMax : lsum_wide[SumW-1:0];
        csum_wide = {1'b0, r_acc_cnt} + {1'b0, r1_cnt};
        n_csum    = csum_wide[CntW] ? '1 : csum_wide[CntW-1:0];
    end

    // state update at the last stage
    always_comb begin
        for (int i = 0; i < NumQuart; i++) begin
            n_q[i] = (r_q[i] == '0 && r3_qhit[i]) ? r3_len : r_q[i];
        end
        for (int i = 0; i < NumLimits; i++) begin
            n_ol[i] = r3_ohit[i] ? r3_csum : r_ol[i];
        end
        for (int i = 0; i < NumNx; i++) begin
            if (!r_reached[i] && (i < NumNx / 2 || r_gen_on) && r3_s100 >= r_tp[i]) begin
                n_reached[i] = 1'b1;
                n_nl[i]      = r3_len;
                n_lx[i]      = r3_csum;
            end else begin
                n_reached[i] = r_reached[i];
                n_nl[i]      = r_nl[i];
                n_lx[i]      = r_lx[i];
            end
        end
    end

    always_comb begin
        o_snap   = '0;
        avail_nx = 1'b0;
        for (int k = 0; k < NumQuart; k++) begin
            o_snap.value[k] = n_q[k];
            o_snap.avail[k] = |n_q[k];
        end
        for (int i = 0; i < NumLimits; i++) begin
            o_snap.value[StatOlBase + i] = n_ol[i];
            o_snap.avail[StatOlBase + i] = 1'b1;
        end
        for (int i = 0; i < NumNx; i++) begin
            avail_nx = n_reached[i] && (i < NumNx / 2 || r_gen_on);
            o_snap.value[StatNxBase + 2*i]     = avail_nx ? n_nl[i] : '0;
            o_snap.value[StatNxBase + 2*i + 1] = avail_nx ? n_lx[i] : '0;
            o_snap.avail[StatNxBase + 2*i]     = avail_nx;
            o_snap.avail[StatNxBase + 2*i + 1] = avail_nx;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_seq     <= '0;
            r_genome  <= '0;
            r_pct_a   <= 7'd50;
            r_pct_b   <= 7'd80;
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r_acc_len <= '0;
            r_acc_cnt <= '0;
            r_q       <= '0;
            r_ol      <= '0;
            r_nl      <= '0;
            r_lx      <= '0;
            r_reached <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    RegTotalLength:  r_total  <= i_cfg_wdata;
                    RegSeqCount:     r_seq    <= i_cfg_wdata[CntW-1:0];
                    RegGenomeLength: r_genome <= i_cfg_wdata;
                    RegPctA:         r_pct_a  <= i_cfg_wdata[PctW-1:0];
                    RegPctB:         r_pct_b  <= i_cfg_wdata[PctW-1:0];
                    default: ;
                endcase
            end
            if (en) begin
                r1_valid <= i_valid;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
                if (r1_valid) begin
                    r_acc_len <= r1_last ? '0 : n_lsum;
                    r_acc_cnt <= r1_last ? '0 : n_csum;
                end
                if (r3_valid) begin
                    if (r3_last) begin
                        r_q       <= '0;
                        r_ol      <= '0;
                        r_nl      <= '0;
                        r_lx      <= '0;
                        r_reached <= '0;
                    end else begin
                        r_q       <= n_q;
                        r_ol      <= n_ol;
                        r_nl      <= n_nl;
                        r_lx      <= n_lx;
                        r_reached <= n_reached;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tp[0]  <= TpW'(r_total) * TpW'(r_pct_a);
        r_tp[1]  <= TpW'(r_total) * TpW'(r_pct_b);
        r_tp[2]  <= TpW'(r_genome) * TpW'(r_pct_a);
        r_tp[3]  <= TpW'(r_genome) * TpW'(r_pct_b);
        r_gen_on <= |r_genome;
        r_half   <= r_seq >> 1;
        r_fourth <= r_seq >> 2;
        r_three  <= (r_seq >> 2) + (r_seq >> 1);
        if (en) begin
            r1_len  <= i_length & LenMask;
            r1_cnt  <= i_count;
            r1_last <= i_last;
            r1_prod <= {32'b0, i_length & LenMask} * {32'b0, i_count};
            r2_lsum <= n_lsum;
            r2_csum <= n_csum;
            r2_len  <= r1_len;
            r2_last <= r1_last;
            // floor(t*p/100) <= s  holds exactly when  t*p <= 100*s + 99
            r3_s100 <= (TpW'(r2_lsum) << 6) + (TpW'(r2_lsum) << 5)
                     + (TpW'(r2_lsum) << 2) + TpW'(99);
            r3_qhit[0] <= r2_csum >= r_three;
            r3_qhit[1] <= r2_csum >= r_half;
            r3_qhit[2] <= r2_csum >= r_fourth;
            for (int i = 0; i < NumLimits; i++) begin
                r3_ohit[i] <= r2_len > Limits[i];
            end
            r3_len  <= r2_len;
            r3_csum <= r2_csum;
            r3_last <= r2_last;
        end
    end

    `AQS_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, en && r1_valid && r1_last, r_acc_cnt == '0)
    `AQS_ASSERT_NXT(a_median_holds, i_clk, i_rst_n, r_q[1] != '0 && !(r3_valid && r3_last), r_q[1] == $past(r_q[1]))

endmodule

`default_nettype wire

// ===== sv/aqs_queue.sv =====
// two-entry queue of finished result sets between front and back
// depends on aqs_pkg and the assertion macro header
`default_nettype none
`include "assembly_nx_quartile_scan_top_macros.svh"

module aqs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aqs_pkg::t_snap i_data,
    output logic           o_full,
    output logic           o_valid,
    output aqs_pkg::t_snap o_data,
    input  logic           i_pop
);
    import aqs_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntQW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0]  LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CntQW-1:0] Full    = CntQW'(QueueDepth);

    t_snap             r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntQW-1:0]  r_cnt;

    assign o_full  = r_cnt == Full;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `AQS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full && !i_pop, !i_push)

endmodule

`default_nettype wire

// ===== sv/aqs_back.sv =====
// back part: walks a queued result set and drives one result per transfer
// depends on aqs_pkg and the assertion macro header
`default_nettype none
`include "assembly_nx_quartile_scan_top_macros.svh"

module aqs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  aqs_pkg::t_snap                i_q_data,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [aqs_pkg::StatIdW-1:0]   o_stat_id,
    output logic [aqs_pkg::StatValW-1:0]  o_stat_value,
    output logic                          o_available,
    output logic                          o_last
);
    import aqs_pkg::*;

    localparam logic [StatIdW-1:0] LastId = StatIdW'(NumStats - 1);

    logic                 r_valid;
    logic [StatIdW-1:0]   r_idx;
    logic [StatIdW-1:0]   r_id;
    logic [StatValW-1:0]  r_value;
    logic                 r_avail, r_last;
    logic                 adv, load;

    assign adv   = !r_valid || i_ready;
    assign load  = adv && i_q_valid;
    assign o_pop = load && (r_idx == LastId);

    assign o_valid      = r_valid;
    assign o_stat_id    = r_id;
    assign o_stat_value = r_value;
    assign o_available  = r_avail;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (adv) begin
                r_valid <= i_q_valid;
            end
            if (load) begin
                r_idx <= (r_idx == LastId) ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_id    <= r_idx;
            r_value <= i_q_data.value[r_idx];
            r_avail <= i_q_data.avail[r_idx];
            r_last  <= r_idx == LastId;
        end
    end

    `AQS_ASSERT_NXT(a_idx_wrap, i_clk, i_rst_n, o_pop, r_idx == '0)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for assembly_nx_quartile_scan_top: streams contig-length histograms,
// predicts the 16 statistics of each run and checks every result transfer in order
// depends on aqs_pkg and the assembly_nx_quartile_scan_top rtl
`default_nettype none

module tb_top;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 80;
    localparam logic [63:0] SUM_MAX      = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] CNT_MAX      = 64'hFFFF_FFFF;
    localparam logic [31:0] SIZE_STEPS [5] = '{32'd500, 32'd1000, 32'd10000, 32'd100000,
                                               32'd1000000};
    localparam int unsigned TX_IDLE  [4] = '{0, 87, 0, 22};
    localparam int unsigned RX_STALL [4] = '{0, 0, 87, 22};

    typedef enum logic [3:0] {
        STAT_Q1, STAT_MEDIAN, STAT_Q3,
        STAT_OVER_500, STAT_OVER_1K, STAT_OVER_10K, STAT_OVER_100K, STAT_OVER_1M,
        STAT_N_A, STAT_L_A, STAT_N_B, STAT_L_B, STAT_N_GA, STAT_L_GA, STAT_N_GB, STAT_L_GB
    } t_stat_id;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] cnt;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic [3:0]  id;
        logic [31:0] value;
        logic        avail;
        logic        last;
    } t_stat;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [2*aqs_pkg::InW-1:0]         s_axis_tdata  = '0;   // length, count
    logic                              s_axis_tlast  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [aqs_pkg::StatValW-1:0]      m_axis_tdata;         // stat_value
    logic [aqs_pkg::TuserW-1:0]        m_axis_tuser;         // stat_id, available
    logic                              m_axis_tlast;
    logic                              i_cfg_we      = 1'b0;
    logic [aqs_pkg::CfgAddrW-1:0]      i_cfg_addr    = '0;
    logic [aqs_pkg::CfgDataW-1:0]      i_cfg_wdata   = '0;

    assembly_nx_quartile_scan_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // register copy, follows the write port
    logic [47:0] cfg_total  = '0;
    logic [31:0] cfg_seqs   = '0;
    logic [47:0] cfg_genome = '0;
    logic [6:0]  cfg_pct_a  = 7'd50;
    logic [6:0]  cfg_pct_b  = 7'd80;

    // scan state of the predictor
    logic [47:0] sum_len;
    logic [31:0] sum_cnt;
    logic [31:0] quart_len [3];
    logic [31:0] over_cnt  [5];
    logic [31:0] nx_len    [4];
    logic [31:0] lx_cnt    [4];
    logic        nx_hit    [4];

    t_entry      pending_entries[$];
    t_stat       expected_stats[$];
    t_entry      tx_item;
    t_stat       mon_want;
    t_stat       mon_got;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          pressure_req = 1'b0;
    bit          rx_hold      = 1'b0;
    int          err_count    = 0;
    int          items_queued = 0;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("** assembly_nx_quartile_scan_top: FAILED **");
        $finish;
    end

    function automatic void clear_scan();
        sum_len = '0;
        sum_cnt = '0;
        for (int k = 0; k < 3; k++) quart_len[k] = '0;
        for (int k = 0; k < 5; k++) over_cnt[k] = '0;
        for (int k = 0; k < 4; k++) begin
            nx_len[k] = '0;
            lx_cnt[k] = '0;
            nx_hit[k] = 1'b0;
        end
    endfunction

    function automatic void push_stat(input t_stat_id id, input logic [31:0] val,
                                      input logic ok);
        t_stat s;
        s.id    = id;
        s.value = ok ? val : '0;
        s.avail = ok;
        s.last  = (id == STAT_L_GB);
        expected_stats.push_back(s);
    endfunction

    function automatic void scan_entry(input t_entry e);
        logic [63:0] prod;
        logic [63:0] csum;
        logic [63:0] half;
        logic [63:0] fourth;
        logic [63:0] three_q;
        logic [63:0] thr [4];
        int          n_act;
        prod = 64'(e.len) * 64'(e.cnt);
        if (prod > SUM_MAX - 64'(sum_len)) begin
            sum_len = '1;
        end else begin
            sum_len = sum_len + 48'(prod);
        end
        csum    = 64'(sum_cnt) + 64'(e.cnt);
        sum_cnt = (csum > CNT_MAX) ? '1 : csum[31:0];
        for (int k = 0; k < 5; k++) begin
            if (e.len > SIZE_STEPS[k]) over_cnt[k] = sum_cnt;
        end
        half    = 64'(cfg_seqs) >> 1;
        fourth  = half >> 1;
        three_q = fourth + half;
        if (quart_len[2] == 0 && 64'(sum_cnt) >= fourth) quart_len[2] = e.len;
        if (quart_len[1] == 0 && 64'(sum_cnt) >= half) quart_len[1] = e.len;
        if (quart_len[0] == 0 && 64'(sum_cnt) >= three_q) quart_len[0] = e.len;
        thr[0] = 64'(cfg_total) * 64'(cfg_pct_a) / 64'd100;
        thr[1] = 64'(cfg_total) * 64'(cfg_pct_b) / 64'd100;
        thr[2] = 64'(cfg_genome) * 64'(cfg_pct_a) / 64'd100;
        thr[3] = 64'(cfg_genome) * 64'(cfg_pct_b) / 64'd100;
        n_act  = (cfg_genome != 0) ? 4 : 2;
        for (int k = 0; k < n_act; k++) begin
            if (!nx_hit[k] && 64'(sum_len) >= thr[k]) begin
                nx_hit[k] = 1'b1;
                nx_len[k] = e.len;
                lx_cnt[k] = sum_cnt;
            end
        end
        if (e.last) begin
            for (int k = 0; k < 3; k++)
                push_stat(t_stat_id'(STAT_Q1 + k), quart_len[k], quart_len[k] != 0);
            for (int k = 0; k < 5; k++)
                push_stat(t_stat_id'(STAT_OVER_500 + k), over_cnt[k], 1'b1);
            for (int k = 0; k < 4; k++) begin
                push_stat(t_stat_id'(STAT_N_A + 2 * k), nx_len[k],
                          nx_hit[k] && (k < 2 || cfg_genome != 0));
                push_stat(t_stat_id'(STAT_L_A + 2 * k), lx_cnt[k],
                          nx_hit[k] && (k < 2 || cfg_genome != 0));
            end
            clear_scan();
        end
    endfunction

    task automatic log_error(input string msg);
        if (err_count < 10) $display("error at %0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_total  <= '0;
            cfg_seqs   <= '0;
            cfg_genome <= '0;
            cfg_pct_a  <= 7'd50;
            cfg_pct_b  <= 7'd80;
        end else if (i_cfg_we) begin
            case (aqs_pkg::t_cfg_reg'(i_cfg_addr))
                aqs_pkg::RegTotalLength:  cfg_total  <= i_cfg_wdata[47:0];
                aqs_pkg::RegSeqCount:     cfg_seqs   <= i_cfg_wdata[31:0];
                aqs_pkg::RegGenomeLength: cfg_genome <= i_cfg_wdata[47:0];
                aqs_pkg::RegPctA:         cfg_pct_a  <= i_cfg_wdata[6:0];
                aqs_pkg::RegPctB:         cfg_pct_b  <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // driver: predicts each entry at its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            clear_scan();
        end else begin
            if (s_axis_tvalid && s_axis_tready) scan_entry(tx_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_entries.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_item = pending_entries.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {tx_item.cnt, tx_item.len};
                    s_axis_tlast  <= tx_item.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got.id    = m_axis_tuser[aqs_pkg::StatIdW-1:0];
                mon_got.value = m_axis_tdata;
                mon_got.avail = m_axis_tuser[aqs_pkg::StatIdW];
                mon_got.last  = m_axis_tlast;
                if (expected_stats.size() == 0) begin
                    log_error($sformatf("unexpected result id %0d value %0h avail %0b",
                                        mon_got.id, mon_got.value, mon_got.avail));
                end else begin
                    mon_want = expected_stats.pop_front();
                    if (mon_got.id != mon_want.id || mon_got.value != mon_want.value ||
                        mon_got.avail != mon_want.avail || mon_got.last != mon_want.last) begin
                        log_error({
                            $sformatf("expected id %0d value %0h avail %0b last %0b, ",
                                      mon_want.id, mon_want.value, mon_want.avail,
                                      mon_want.last),
                            $sformatf("got id %0d value %0h avail %0b last %0b",
                                      mon_got.id, mon_got.value, mon_got.avail,
                                      mon_got.last)});
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the result queue fills and the input stalls
    initial begin
        wait (pressure_req);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_entries.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input aqs_pkg::t_cfg_reg idx,
                           input logic [aqs_pkg::CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic program_regs(input logic [47:0] tot, input logic [31:0] seqs,
                                input logic [47:0] gen, input logic [6:0] pa,
                                input logic [6:0] pb);
        put_reg(aqs_pkg::RegTotalLength, tot);
        put_reg(aqs_pkg::RegSeqCount, 48'(seqs));
        put_reg(aqs_pkg::RegGenomeLength, gen);
        put_reg(aqs_pkg::RegPctA, 48'(pa));
        put_reg(aqs_pkg::RegPctB, 48'(pb));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic launch(input t_entry ents[$], input bit reconfigure,
                          input logic [47:0] tot, input logic [31:0] seqs,
                          input logic [47:0] gen, input logic [6:0] pa, input logic [6:0] pb);
        if (reconfigure) begin
            wait_idle();
            program_regs(tot, seqs, gen, pa, pb);
        end
        foreach (ents[k]) pending_entries.push_back(ents[k]);
        items_queued += ents.size();
    endtask

    function automatic logic [47:0] sum_bases(input t_entry ents[$]);
        logic [63:0] acc;
        acc = '0;
        foreach (ents[k]) begin
            acc = acc + 64'(ents[k].len) * 64'(ents[k].cnt);
            if (acc > SUM_MAX) acc = SUM_MAX;
        end
        return acc[47:0];
    endfunction

    function automatic logic [31:0] sum_contigs(input t_entry ents[$]);
        logic [63:0] acc;
        acc = '0;
        foreach (ents[k]) begin
            acc = acc + 64'(ents[k].cnt);
            if (acc > CNT_MAX) acc = CNT_MAX;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85) return 32'($urandom_range(1, 50));
        if (r < 95) return 32'($urandom_range(1, 100000));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_top_length();
        case ($urandom_range(5))
            0:       return ($urandom == 0) ? 32'd1 : $urandom | 32'd1;
            1:       return 32'($urandom_range(1, 5000000));
            2:       return 32'($urandom_range(1, 500000));
            3:       return 32'($urandom_range(1, 50000));
            4:       return 32'($urandom_range(1, 5000));
            default: return 32'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [6:0] pick_pct();
        if ($urandom_range(9) == 0) return ($urandom_range(1) == 0) ? 7'd1 : 7'd99;
        return 7'($urandom_range(1, 99));
    endfunction

    // tidy runs are strictly descending with matching totals, the rest is noise
    task automatic random_histogram(input int n, input bit tidy, input bit reconfigure);
        t_entry      ents[$];
        t_entry      e;
        logic [31:0] len;
        logic [47:0] tot;
        logic [47:0] gen;
        logic [31:0] seqs;
        logic [6:0]  pa;
        logic [6:0]  pb;
        len = pick_top_length();
        for (int k = 0; k < n; k++) begin
            e.len  = len;
            e.cnt  = pick_count();
            e.last = (k == n - 1) || (tidy && len == 32'd1) ||
                     (!tidy && $urandom_range(9) == 0);
            ents.push_back(e);
            if (e.last && tidy) break;
            len = tidy ? len - 32'd1 - ($urandom % ((len - 32'd1) / 32'd2 + 32'd1))
                       : pick_top_length();
        end
        if (tidy) begin
            tot  = sum_bases(ents);
            seqs = sum_contigs(ents);
            gen  = ($urandom_range(3) == 0) ? '0 :
                   48'((64'(tot) * 64'($urandom_range(50, 150))) / 64'd100);
            pa   = pick_pct();
            pb   = pick_pct();
        end else begin
            tot  = 48'({$urandom, $urandom}) >> $urandom_range(47);
            seqs = $urandom >> $urandom_range(31);
            gen  = ($urandom_range(1) == 0) ? '0 :
                   48'({$urandom, $urandom}) >> $urandom_range(47);
            pa   = 7'($urandom_range(127));
            pb   = 7'($urandom_range(127));
        end
        launch(ents, reconfigure, tot, seqs, gen, pa, pb);
    endtask

    initial begin
        t_entry ents[$];
        int     sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero totals, every active threshold met at once
        ents = '{'{32'hFFFF_FFFF, 32'd1, 1'b1}};
        launch(ents, 1'b0, '0, '0, '0, 7'd0, 7'd0);

        // lengths straddling every size step, genome statistics on
        ents = '{'{32'd2000000, 32'd1, 1'b0}, '{32'd150000, 32'd2, 1'b0},
                 '{32'd20000, 32'd3, 1'b0}, '{32'd5000, 32'd4, 1'b0},
                 '{32'd800, 32'd5, 1'b0}, '{32'd500, 32'd6, 1'b0},
                 '{32'd300, 32'd7, 1'b0}, '{32'd1, 32'd8, 1'b1}};
        launch(ents, 1'b1, sum_bases(ents), sum_contigs(ents), 48'd3000000, 7'd50, 7'd80);

        // both sums saturate, percentages zero and above one hundred
        ents = '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0},
                 '{32'd7, 32'd3, 1'b1}};
        launch(ents, 1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               7'd0, 7'd127);

        // zero lengths and zero counts, genome unset
        ents = '{'{32'd50, 32'd0, 1'b0}, '{32'd40, 32'd2, 1'b0}, '{32'd0, 32'd5, 1'b0},
                 '{32'd0, 32'd0, 1'b1}};
        launch(ents, 1'b1, 48'd100, 32'd10, '0, 7'd1, 7'd99);

        // contig count too large for any quartile to be found
        ents = '{'{32'd300, 32'd2, 1'b0}, '{32'd200, 32'd1, 1'b0}, '{32'd100, 32'd1, 1'b1}};
        launch(ents, 1'b1, 48'd1000, 32'd4000000000, 48'd500, 7'd99, 7'd1);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            tx_idle_pct  = TX_IDLE[ph];
            rx_stall_pct = RX_STALL[ph];
            if (ph == 0) begin
                random_histogram(3, 1'b1, 1'b1);
                pressure_req = 1'b1;
                for (int h = 0; h < 12; h++)
                    random_histogram($urandom_range(1, 3), 1'b1, 1'b0);
            end
            sent = items_queued;
            while (items_queued - sent < PHASE_ITEMS)
                random_histogram($urandom_range(1, 8), $urandom_range(99) < 75, 1'b1);
        end

        wait_idle();
        if (err_count == 0) begin
            $display("** assembly_nx_quartile_scan_top: PASSED **");
        end else begin
            $display("** assembly_nx_quartile_scan_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
